/* rtl/ordered_list_table_engine_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef ORDERED_LIST_TABLE_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define OLTE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define OLTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/olte_pkg.sv */
package olte_pkg;

  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int POS_W     = 10;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 3;
  localparam int IDX_W     = 11;
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 56;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_REPLACE = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_INSERT  = 3'd4,
    OP_MAX     = 3'd5
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_SHDN,
    S_SHUP,
    S_MAX,
    S_RESP
  } state_t;

endpackage

/* rtl/ordered_list_table_engine_core.sv */
// Ordered list engine: a packed list of up to 1024 signed 32-bit entries plus a count.
// Input channel s_*: one command per beat. s_tuser holds the opcode (append, replace,
// delete, search, insert at position, max); s_tdata holds value, new_value, position.
// Output channel m_*: exactly one result beat per command. m_tuser holds the status;
// m_tdata holds index, result_value and the entry count after the command.
// Commands run one at a time; s_tready is high only while the engine is idle, and
// the next command is taken once the previous result beat has been taken.
// The list lives in a single-port-read, single-port-write memory with registered read;
// one shared comparator and one address walker do all scanning, one entry per cycle.
// Command time follows the walk: append and rejected commands run no walk; search and
// replace walk up to the match (the whole list on a miss); delete walks the whole list,
// moving the entries after a match down; insert walks from the end down to position;
// max walks the whole list. The longest is a delete of the first entry of a full list,
// set by the one-entry-per-cycle memory walk.
// Reset (rst, synchronous) empties the list at once; no clearing pass is run.
// If the receiver holds m_tready low, the result beat holds and no command is taken.
module ordered_list_table_engine_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [31:0] value, [63:32] new_value, [73:64] position, [79:74] zero
  input  logic [olte_pkg::S_TDATA_W-1:0] s_tdata,
  // [2:0] opcode
  input  logic [olte_pkg::OP_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [10:0] index, [42:11] result_value, [53:43] count, [55:54] zero
  output logic [olte_pkg::M_TDATA_W-1:0] m_tdata,
  // [2:0] status
  output logic [olte_pkg::STAT_W-1:0]    m_tuser
);
  import olte_pkg::*;

  state_t              state, state_next;
  logic [OP_W-1:0]     op, op_next;
  logic [DATA_W-1:0]   val, val_next;
  logic [DATA_W-1:0]   nval, nval_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [CNT_W-1:0]    ptr, ptr_next;
  logic [CNT_W-1:0]    rem, rem_next;
  logic [ADDR_W-1:0]   wa, wa_next;
  logic [ADDR_W-1:0]   tag, tag_next;
  logic                pend, pend_next;
  logic                first, first_next;
  status_t             o_status, o_status_next;
  logic [IDX_W-1:0]    o_index, o_index_next;
  logic [DATA_W-1:0]   o_value, o_value_next;

  logic [DATA_W-1:0]   mem [DEPTH];
  logic [DATA_W-1:0]   rd_data;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_wa, mem_ra;
  logic [DATA_W-1:0]   mem_wd;

  logic [DATA_W-1:0]   cmp_b;
  logic                cmp_eq, cmp_gt, match;
  logic                full, scan_end, shup_end;

  // shared compare unit: equality for the find walk, signed greater for max
  assign cmp_b    = (state == S_MAX) ? o_value : val;
  assign cmp_eq   = (rd_data == cmp_b);
  assign cmp_gt   = ($signed(rd_data) > $signed(cmp_b));
  assign match    = pend && cmp_eq;
  assign full     = (cnt >= CNT_W'(DEPTH));
  assign scan_end = !pend && (ptr >= cnt);
  assign shup_end = !pend && (rem == '0);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (op)
          OP_REPLACE, OP_DELETE, OP_SEARCH: state_next = S_FIND;
          OP_INSERT: begin
            if (CNT_W'(pos) < cnt && !full) state_next = S_SHUP;
            else state_next = S_RESP;
          end
          OP_MAX: begin
            if (cnt != '0) state_next = S_MAX;
            else state_next = S_RESP;
          end
          default: state_next = S_RESP;
        endcase
      end
      S_FIND: begin
        if (match) begin
          if (op == OP_DELETE) state_next = S_SHDN;
          else state_next = S_RESP;
        end else if (ptr >= cnt) begin
          state_next = S_RESP;
        end
      end
      S_SHDN: begin
        if (scan_end) state_next = S_RESP;
      end
      S_SHUP: begin
        if (shup_end) state_next = S_RESP;
      end
      S_MAX: begin
        if (scan_end) state_next = S_RESP;
      end
      S_RESP: begin
        if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op_next       = op;
    val_next      = val;
    nval_next     = nval;
    pos_next      = pos;
    cnt_next      = cnt;
    ptr_next      = ptr;
    rem_next      = rem;
    wa_next       = wa;
    tag_next      = tag;
    pend_next     = pend;
    first_next    = first;
    o_status_next = o_status;
    o_index_next  = o_index;
    o_value_next  = o_value;
    mem_we        = 1'b0;
    mem_wa        = wa;
    mem_wd        = rd_data;
    mem_re        = 1'b0;
    mem_ra        = ptr[ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_next   = s_tuser;
          val_next  = s_tdata[DATA_W-1:0];
          nval_next = s_tdata[2*DATA_W-1:DATA_W];
          pos_next  = s_tdata[2*DATA_W+POS_W-1:2*DATA_W];
        end
      end
      S_DECODE: begin
        ptr_next      = '0;
        pend_next     = 1'b0;
        first_next    = 1'b1;
        o_status_next = ST_OK;
        o_index_next  = '0;
        o_value_next  = '0;
        case (op)
          OP_APPEND: begin
            if (full) begin
              o_status_next = ST_FULL;
            end else begin
              mem_we       = 1'b1;
              mem_wa       = cnt[ADDR_W-1:0];
              mem_wd       = val;
              o_index_next = IDX_W'(cnt);
              cnt_next     = cnt + 1'b1;
            end
          end
          OP_INSERT: begin
            if (CNT_W'(pos) >= cnt) begin
              o_status_next = ST_BAD_POS;
            end else if (full) begin
              o_status_next = ST_FULL;
            end else begin
              ptr_next = cnt - 1'b1;
              wa_next  = cnt[ADDR_W-1:0];
              rem_next = cnt - CNT_W'(pos);
            end
          end
          OP_MAX: begin
            if (cnt == '0) o_status_next = ST_EMPTY;
          end
          default: ;
        endcase
      end
      S_FIND: begin
        if (match) begin
          pend_next    = 1'b0;
          o_index_next = IDX_W'(tag);
          if (op == OP_REPLACE) begin
            mem_we = 1'b1;
            mem_wa = tag;
            mem_wd = nval;
          end
          // delete: start moving entries down into the matched slot
          wa_next = tag;
        end else if (ptr < cnt) begin
          mem_re    = 1'b1;
          tag_next  = ptr[ADDR_W-1:0];
          pend_next = 1'b1;
          ptr_next  = ptr + 1'b1;
        end else begin
          pend_next     = 1'b0;
          o_status_next = ST_NOT_FOUND;
          o_index_next  = '0;
        end
      end
      S_SHDN: begin
        if (pend) begin
          mem_we  = 1'b1;
          wa_next = wa + 1'b1;
        end
        if (ptr < cnt) begin
          mem_re    = 1'b1;
          pend_next = 1'b1;
          ptr_next  = ptr + 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (scan_end) cnt_next = cnt - 1'b1;
      end
      S_SHUP: begin
        if (pend) begin
          mem_we  = 1'b1;
          wa_next = wa - 1'b1;
        end
        if (rem != '0) begin
          mem_re    = 1'b1;
          pend_next = 1'b1;
          ptr_next  = ptr - 1'b1;
          rem_next  = rem - 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        // all moves done: the write pointer has landed on position
        if (shup_end) begin
          mem_we       = 1'b1;
          mem_wd       = val;
          cnt_next     = cnt + 1'b1;
          o_index_next = IDX_W'(pos);
        end
      end
      S_MAX: begin
        if (pend) begin
          first_next = 1'b0;
          if (first || cmp_gt) o_value_next = rd_data;
        end
        if (ptr < cnt) begin
          mem_re    = 1'b1;
          pend_next = 1'b1;
          ptr_next  = ptr + 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
    op       <= op_next;
    val      <= val_next;
    nval     <= nval_next;
    pos      <= pos_next;
    ptr      <= ptr_next;
    rem      <= rem_next;
    wa       <= wa_next;
    tag      <= tag_next;
    first    <= first_next;
    o_status <= o_status_next;
    o_index  <= o_index_next;
    o_value  <= o_value_next;
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_RESP);
  assign m_tuser  = o_status;
  assign m_tdata  = {{(M_TDATA_W - 2*IDX_W - DATA_W){1'b0}}, IDX_W'(cnt), o_value, o_index};

endmodule

/* rtl/olte_checker.sv */
`include "ordered_list_table_engine_core_assert.svh"

module olte_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [olte_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [olte_pkg::STAT_W-1:0]    m_tuser
);
  import olte_pkg::*;

  logic [IDX_W-1:0] m_index;
  logic [IDX_W-1:0] m_count;
  logic             m_stall;
  logic             m_error;

  assign m_index = m_tdata[IDX_W-1:0];
  assign m_count = m_tdata[2*IDX_W+DATA_W-1:IDX_W+DATA_W];
  assign m_stall = m_tvalid && !m_tready;
  assign m_error = m_tvalid && (m_tuser != ST_OK);

  `OLTE_ASSERT_NEXT(a_result_holds, clk, rst, m_stall, m_tvalid && $stable({m_tdata, m_tuser}), "beat moved in stall")
  `OLTE_ASSERT_NOW(a_one_at_a_time, clk, rst, s_tready, !m_tvalid, "command taken with result pending")
  `OLTE_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "taken while busy")
  `OLTE_ASSERT_NOW(a_error_index_zero, clk, rst, m_error, m_index == '0, "nonzero index on error")
  `OLTE_ASSERT_NOW(a_count_bound, clk, rst, m_tvalid, m_count <= IDX_W'(DEPTH), "count above depth")

endmodule

bind ordered_list_table_engine_core olte_checker u_olte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
